// File: rtl/core/periodic_timer_list_top_assert.svh
// Assertion macros shared by the periodic timer list RTL
`ifndef PERIODIC_TIMER_LIST_TOP_ASSERT_SVH
`define PERIODIC_TIMER_LIST_TOP_ASSERT_SVH

// Property must hold at every clock edge outside reset
`define PTL_ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PTL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/ptl_pkg.sv
// Types and constants of the periodic timer list
`timescale 1ns / 1ps

package ptl_pkg;

  // Most fired results a single tick may give
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned FIRE_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_DEL   = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_FIRED    = 3'd0,
    KIND_ADDED    = 3'd1,
    KIND_FULL     = 3'd2,
    KIND_ZERO     = 3'd3,
    KIND_DEL_MARK = 3'd4,
    KIND_DEL_MISS = 3'd5,
    KIND_CLEARED  = 3'd6
  } kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  // One stored timer
  typedef struct packed {
    logic [31:0] id;
    logic [31:0] period;
    logic [31:0] last_run;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic finish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage

// File: rtl/core/ptl_ctrl.sv
// Controller state machine of the periodic timer list
`timescale 1ns / 1ps

module ptl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       mode_i,
  input  ptl_pkg::sts_t    sts_i,
  output ptl_pkg::cmd_t    cmd_o,
  output logic             busy_o
);

  ptl_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b0;
    unique case (state_q)
      ptl_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          // tick and delete walk the list, add and clear finish at once
          if ((mode_i == ptl_pkg::MODE_TICK) || (mode_i == ptl_pkg::MODE_DEL)) begin
            state_d = ptl_pkg::ST_SCAN;
          end
        end
      end
      ptl_pkg::ST_SCAN: begin
        busy_o     = 1'b1;
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.finish = 1'b1;
          state_d      = ptl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ptl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/ptl_datapath.sv
// Datapath of the periodic timer list: entry memory, marks, scan pipeline, results
`timescale 1ns / 1ps
`include "periodic_timer_list_top_assert.svh"

module ptl_datapath #(
  parameter int unsigned SLOTS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ptl_pkg::cmd_t    cmd_i,
  output ptl_pkg::sts_t    sts_o,
  input  logic [1:0]       mode_i,
  input  logic [31:0]      timer_id_i,
  input  logic [31:0]      interval_ms_i,
  input  logic [31:0]      now_ms_i,
  output logic             strobe_o,
  output logic [2:0]       kind_o,
  output logic [31:0]      event_id_o,
  output logic             last_o
);

  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned FIRE_W = ptl_pkg::FIRE_W;

  // Entry memory, no reset: only entries below the fill count are read
  ptl_pkg::entry_t mem_q [SLOTS];
  ptl_pkg::entry_t rdata_q;
  logic            mem_we;
  logic [IDX_W-1:0] mem_waddr;
  ptl_pkg::entry_t mem_wdata;

  // Control state
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  rd_q, rd_d;
  logic [CNT_W-1:0]  wr_q, wr_d;
  logic [FIRE_W-1:0] fire_q, fire_d;
  logic              hit_q, hit_d;
  logic              p1_vld_q, p1_vld_d;
  logic              hold_vld_q, hold_vld_d;
  logic              strobe_q, strobe_d;
  logic [SLOTS-1:0]  mark_q, mark_d;

  // Payload state
  ptl_pkg::mode_e    req_mode_q, req_mode_d;
  logic [31:0]       req_id_q, req_id_d;
  logic [31:0]       req_now_q, req_now_d;
  logic [IDX_W-1:0]  p1_idx_q, p1_idx_d;
  logic              p1_mark_q, p1_mark_d;
  logic [31:0]       hold_id_q, hold_id_d;
  ptl_pkg::kind_e    kind_q, kind_d;
  logic [31:0]       id_q, id_d;
  logic              last_q, last_d;

  // Scan decode
  logic        issue;
  logic        is_tick;
  logic        keep;
  logic [31:0] elapsed;
  logic        due;
  logic        fire;
  logic        del_hit;
  logic        add_ok;
  logic        is_full;

  assign is_tick = (req_mode_q == ptl_pkg::MODE_TICK);
  assign is_full = (cnt_q == CNT_W'(SLOTS));
  assign issue   = cmd_i.scan && (rd_q < cnt_q) && !hit_q;
  assign keep    = p1_vld_q && is_tick && !p1_mark_q;
  assign elapsed = req_now_q - rdata_q.last_run;
  assign due     = (elapsed >= rdata_q.period);
  assign fire    = keep && due && (fire_q < FIRE_W'(ptl_pkg::MAX_RESULTS));
  assign del_hit = p1_vld_q && !is_tick && !hit_q && (rdata_q.id == req_id_q);
  assign add_ok  = cmd_i.accept && (mode_i == ptl_pkg::MODE_ADD) &&
                   (interval_ms_i != 32'd0) && !is_full;

  assign sts_o.scan_done = !p1_vld_q && ((rd_q >= cnt_q) || hit_q);

  // Memory write port: add appends at the fill count, tick compacts at wr
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q[IDX_W-1:0];
    mem_wdata = '{id: timer_id_i, period: interval_ms_i, last_run: now_ms_i};
    if (add_ok) begin
      mem_we = 1'b1;
    end else if (keep) begin
      mem_we    = 1'b1;
      mem_waddr = wr_q[IDX_W-1:0];
      mem_wdata = '{id: rdata_q.id, period: rdata_q.period,
                    last_run: fire ? req_now_q : rdata_q.last_run};
    end
  end

  // Memory with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rdata_q <= mem_q[rd_q[IDX_W-1:0]];
    end
  end

  // Next state of the whole datapath
  always_comb begin
    cnt_d      = cnt_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    fire_d     = fire_q;
    hit_d      = hit_q;
    hold_vld_d = hold_vld_q;
    mark_d     = mark_q;
    req_mode_d = req_mode_q;
    req_id_d   = req_id_q;
    req_now_d  = req_now_q;
    hold_id_d  = hold_id_q;
    kind_d     = kind_q;
    id_d       = id_q;
    last_d     = last_q;
    strobe_d   = 1'b0;
    p1_vld_d   = issue;
    p1_idx_d   = rd_q[IDX_W-1:0];
    p1_mark_d  = mark_q[rd_q[IDX_W-1:0]];

    // New request
    if (cmd_i.accept) begin
      unique case (mode_i) inside
        ptl_pkg::MODE_TICK, ptl_pkg::MODE_DEL: begin
          req_mode_d = ptl_pkg::mode_e'(mode_i);
          req_id_d   = timer_id_i;
          req_now_d  = now_ms_i;
          rd_d       = '0;
          wr_d       = '0;
          fire_d     = '0;
          hit_d      = 1'b0;
          hold_vld_d = 1'b0;
        end
        ptl_pkg::MODE_ADD: begin
          strobe_d = 1'b1;
          last_d   = 1'b1;
          id_d     = timer_id_i;
          if (interval_ms_i == 32'd0) begin
            kind_d = ptl_pkg::KIND_ZERO;
          end else if (is_full) begin
            kind_d = ptl_pkg::KIND_FULL;
          end else begin
            kind_d                    = ptl_pkg::KIND_ADDED;
            cnt_d                     = cnt_q + CNT_W'(1);
            mark_d[cnt_q[IDX_W-1:0]]  = 1'b0;
          end
        end
        default: begin
          // clear all: marks beyond the fill count are never looked at
          mark_d   = '1;
          strobe_d = 1'b1;
          last_d   = 1'b1;
          kind_d   = ptl_pkg::KIND_CLEARED;
          id_d     = 32'd0;
        end
      endcase
    end

    // Scan step
    if (cmd_i.scan) begin
      if (issue) begin
        rd_d = rd_q + CNT_W'(1);
      end
      if (keep) begin
        wr_d                    = wr_q + CNT_W'(1);
        mark_d[wr_q[IDX_W-1:0]] = 1'b0;
      end
      // a fire releases the previous one, which is then known not to be last
      if (fire) begin
        fire_d     = fire_q + FIRE_W'(1);
        hold_vld_d = 1'b1;
        hold_id_d  = rdata_q.id;
        if (hold_vld_q) begin
          strobe_d = 1'b1;
          kind_d   = ptl_pkg::KIND_FIRED;
          id_d     = hold_id_q;
          last_d   = 1'b0;
        end
      end
      if (del_hit) begin
        hit_d              = 1'b1;
        mark_d[p1_idx_q]   = 1'b1;
      end
    end

    // End of scan
    if (cmd_i.finish) begin
      if (is_tick) begin
        cnt_d      = wr_q;
        hold_vld_d = 1'b0;
        if (hold_vld_q) begin
          strobe_d = 1'b1;
          kind_d   = ptl_pkg::KIND_FIRED;
          id_d     = hold_id_q;
          last_d   = 1'b1;
        end
      end else begin
        strobe_d = 1'b1;
        kind_d   = hit_q ? ptl_pkg::KIND_DEL_MARK : ptl_pkg::KIND_DEL_MISS;
        id_d     = req_id_q;
        last_d   = 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      fire_q     <= '0;
      hit_q      <= 1'b0;
      p1_vld_q   <= 1'b0;
      hold_vld_q <= 1'b0;
      strobe_q   <= 1'b0;
      mark_q     <= '0;
    end else begin
      cnt_q      <= cnt_d;
      rd_q       <= rd_d;
      wr_q       <= wr_d;
      fire_q     <= fire_d;
      hit_q      <= hit_d;
      p1_vld_q   <= p1_vld_d;
      hold_vld_q <= hold_vld_d;
      strobe_q   <= strobe_d;
      mark_q     <= mark_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_mode_q <= req_mode_d;
    req_id_q   <= req_id_d;
    req_now_q  <= req_now_d;
    p1_idx_q   <= p1_idx_d;
    p1_mark_q  <= p1_mark_d;
    hold_id_q  <= hold_id_d;
    kind_q     <= kind_d;
    id_q       <= id_d;
    last_q     <= last_d;
  end

  assign strobe_o   = strobe_q;
  assign kind_o     = kind_q;
  assign event_id_o = id_q;
  assign last_o     = last_q;

  // Checks
  `PTL_ASSERT_HOLDS(a_cnt_range, clk_i, rst_ni, cnt_q <= CNT_W'(SLOTS), "fill count past list size")
  `PTL_ASSERT_HOLDS(a_wr_behind_rd, clk_i, rst_ni, wr_q <= rd_q, "compaction write ahead of read")
  `PTL_ASSERT_HOLDS(a_fire_cap, clk_i, rst_ni, fire_q <= FIRE_W'(ptl_pkg::MAX_RESULTS), "fire count past cap")
  `PTL_ASSERT_NEXT(a_add_result, clk_i, rst_ni, cmd_i.accept && (mode_i == ptl_pkg::MODE_ADD), strobe_q, "add gave no result")

endmodule

// File: rtl/core/periodic_timer_list_top.sv
// Top level of the periodic timer list
`timescale 1ns / 1ps

// Periodic timer list of up to SLOTS entries. A request is taken when start_i is high and
// busy_o is low. Add, zero-interval, full and clear requests give their single result in the
// cycle after and leave busy_o low, so a new request may follow at once. Tick and delete walk
// the list through the entry memory, one entry per cycle behind a registered read: a tick
// holds busy_o through a walk of every entry below the fill count, that count still including
// marked entries; a delete stops its walk once the matching entry is read. Tick results (one
// per fired timer, at most 16) come out during and at the end of the walk, the last one flagged
// by last_o. Every result is shown for one cycle with strobe_o high and cannot be held off by
// the receiver, who must take it in that cycle.
module periodic_timer_list_top #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] timer_id_i,
  input  logic [31:0] interval_ms_i,
  input  logic [31:0] now_ms_i,
  output logic        strobe_o,
  output logic [2:0]  kind_o,
  output logic [31:0] event_id_o,
  output logic        last_o
);

  ptl_pkg::cmd_t cmd;
  ptl_pkg::sts_t sts;

  // Sequencer
  ptl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .mode_i  (mode_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // Storage and result path
  ptl_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (mode_i),
    .timer_id_i    (timer_id_i),
    .interval_ms_i (interval_ms_i),
    .now_ms_i      (now_ms_i),
    .strobe_o      (strobe_o),
    .kind_o        (kind_o),
    .event_id_o    (event_id_o),
    .last_o        (last_o)
  );

endmodule
